@@ hdl/pac_pkg.sv @@
package pac_pkg;

    // default geometry
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_COORD_BITS   = 16;

    // result field widths
    localparam int TA_W  = 35;
    localparam int NUM_W = 52;
    localparam int DEN_W = 35;

    // accumulators never grow past this, sums wrap beyond it
    localparam int ACC_MAX_W = 64;

    localparam logic signed [ACC_MAX_W-1:0] AREA_LIMIT = 64'sd8589934592;
    localparam logic signed [ACC_MAX_W-1:0] NUM_LIMIT  = 64'sd1125899906842624;

    localparam int         I_ZERO  = 0;
    localparam logic [1:0] I_THREE = 2'd3;

    // symmetric saturation to +-lim
    function automatic logic signed [ACC_MAX_W-1:0] sat_sym(
        input logic signed [ACC_MAX_W-1:0] v,
        input logic signed [ACC_MAX_W-1:0] lim
    );
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

endpackage

@@ hdl/polygon_area_centroid_core.sv @@
// polygon area and centroid by the shoelace sum
//
// vertices arrive on the input channel (i_in_valid / o_in_stall) in ring order,
// one request per vertex, with i_last_vertex set on the final one. the result
// channel (o_out_valid / i_out_stall) carries one request per polygon: twice
// the signed area and the centroid as num_x / denom, num_y / denom. a polygon
// with non-positive area reports the plain vertex average with the vertex
// count as denom. vertices past MAX_VERTICES are dropped and raise too_many.
//
// sequencing: one signed multiplier serves the four products of an edge, so an
// edge runs as a series of steps (two cross terms, a subtract, two weighted
// terms, the last accumulate). a first or dropped vertex that is not final
// is taken straight in, any other vertex runs an edge. a final vertex adds
// the closing edge, a saturation step and an output load; a lone or dropped
// final vertex runs only the closing edge. the next vertex waits for the load.
// the input side stalls while a vertex is in work. the result sits in an
// output register; if the receiver stalls, the next polygon is still taken
// and only its finishing step waits for the register to drain.
// synchronous reset clears all sums, the vertex count and the output valid.
module polygon_area_centroid_core
    import pac_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic                         i_last_vertex,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [TA_W-1:0]       o_twice_area,
    output logic signed [NUM_W-1:0]      o_num_x,
    output logic signed [NUM_W-1:0]      o_num_y,
    output logic [DEN_W-1:0]             o_denom,
    output logic                         o_too_many
);

    // operand and accumulator widths
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int SA_W    = COORD_BITS + 1;           // coordinate pair sum
    localparam int PROD_W  = 2 * COORD_BITS + 1;       // edge cross product
    localparam int WPROD_W = SA_W + PROD_W;            // multiplier result
    localparam int AREA_W  = (PROD_W + CNT_W > ACC_MAX_W) ? ACC_MAX_W : PROD_W + CNT_W;
    localparam int WACC_W  = (WPROD_W + CNT_W > ACC_MAX_W) ? ACC_MAX_W : WPROD_W + CNT_W;
    localparam int PACC_W  = (COORD_BITS + CNT_W > ACC_MAX_W) ? ACC_MAX_W : COORD_BITS + CNT_W;

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;   // ax*by
    localparam logic [3:0] S_M1   = 4'd2;   // bx*ay
    localparam logic [3:0] S_M2   = 4'd3;   // cross product
    localparam logic [3:0] S_M3   = 4'd4;   // (ax+bx)*c, area sum
    localparam logic [3:0] S_M4   = 4'd5;   // (ay+by)*c, x sum
    localparam logic [3:0] S_M5   = 4'd6;   // y sum, pick next edge
    localparam logic [3:0] S_FIN0 = 4'd7;   // saturate
    localparam logic [3:0] S_FIN1 = 4'd8;   // hand result over

    logic [3:0]                r_state;
    logic [CNT_W-1:0]          r_count;
    logic                      r_ovf;
    logic                      r_last;
    logic                      r_close;
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [AREA_W-1:0]  r_area;
    logic signed [WACC_W-1:0]  r_wx, r_wy;
    logic signed [PACC_W-1:0]  r_px, r_py;
    logic signed [WPROD_W-1:0] r_p;
    logic signed [PROD_W-1:0]  r_c;
    logic signed [TA_W-1:0]    r_ta;
    logic signed [NUM_W-1:0]   r_nx, r_ny;
    logic                      r_pos;
    logic                      r_out_valid;
    logic signed [TA_W-1:0]    r_out_ta;
    logic signed [NUM_W-1:0]   r_out_nx, r_out_ny;
    logic [DEN_W-1:0]          r_out_den;
    logic                      r_out_ovf;

    logic                      in_acc;
    logic                      out_free;
    logic signed [SA_W-1:0]    mul_a;
    logic signed [PROD_W-1:0]  mul_b;
    logic signed [WPROD_W-1:0] mul_p;
    logic signed [ACC_MAX_W-1:0] area_ext, wx_ext, wy_ext, px_ext, py_ext;
    logic signed [ACC_MAX_W-1:0] ta_sat, nx_sat, ny_sat;
    logic [DEN_W-1:0]          den_calc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_M1: begin
                mul_a = SA_W'(r_bx);
                mul_b = PROD_W'(r_ay);
            end
            S_M3: begin
                mul_a = SA_W'(r_ax) + SA_W'(r_bx);
                mul_b = r_c;
            end
            S_M4: begin
                mul_a = SA_W'(r_ay) + SA_W'(r_by);
                mul_b = r_c;
            end
            default: begin
                mul_a = SA_W'(r_ax);
                mul_b = PROD_W'(r_by);
            end
        endcase
    end

    assign mul_p = WPROD_W'(mul_a) * WPROD_W'(mul_b);

    // saturation of the closed sums
    assign area_ext = ACC_MAX_W'(r_area);
    assign wx_ext   = ACC_MAX_W'(r_wx);
    assign wy_ext   = ACC_MAX_W'(r_wy);
    assign px_ext   = ACC_MAX_W'(r_px);
    assign py_ext   = ACC_MAX_W'(r_py);
    assign ta_sat   = sat_sym(area_ext, AREA_LIMIT);
    assign nx_sat   = (area_ext > ACC_MAX_W'(I_ZERO)) ? sat_sym(wx_ext, NUM_LIMIT)
                                                      : sat_sym(px_ext, NUM_LIMIT);
    assign ny_sat   = (area_ext > ACC_MAX_W'(I_ZERO)) ? sat_sym(wy_ext, NUM_LIMIT)
                                                      : sat_sym(py_ext, NUM_LIMIT);

    // denominator: three times twice the area, else the vertex count
    assign den_calc = r_pos ? DEN_W'($unsigned(r_ta) * DEN_W'(I_THREE))
                            : DEN_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_last      <= 1'b0;
            r_close     <= 1'b0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_ax        <= '0;
            r_ay        <= '0;
            r_bx        <= '0;
            r_by        <= '0;
            r_area      <= '0;
            r_wx        <= '0;
            r_wy        <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_p         <= '0;
            r_c         <= '0;
            r_ta        <= '0;
            r_nx        <= '0;
            r_ny        <= '0;
            r_pos       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_ta    <= '0;
            r_out_nx    <= '0;
            r_out_ny    <= '0;
            r_out_den   <= '0;
            r_out_ovf   <= 1'b0;
        end else begin
            r_p <= mul_p;
            // drained result, unless a new one is loaded below
            if (r_out_valid && !i_out_stall && (r_state != S_FIN1)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_last <= i_last_vertex;
                        if (r_count < CNT_W'(MAX_VERTICES)) begin
                            r_count  <= r_count + 1'b1;
                            r_prev_x <= i_vertex_x;
                            r_prev_y <= i_vertex_y;
                            r_px     <= r_px + PACC_W'(i_vertex_x);
                            r_py     <= r_py + PACC_W'(i_vertex_y);
                            if (r_count == '0) begin
                                // lone vertex closes onto itself
                                r_first_x <= i_vertex_x;
                                r_first_y <= i_vertex_y;
                                r_ax      <= i_vertex_x;
                                r_ay      <= i_vertex_y;
                                r_bx      <= i_vertex_x;
                                r_by      <= i_vertex_y;
                                r_close   <= 1'b1;
                                r_state   <= i_last_vertex ? S_M0 : S_IDLE;
                            end else begin
                                r_ax    <= r_prev_x;
                                r_ay    <= r_prev_y;
                                r_bx    <= i_vertex_x;
                                r_by    <= i_vertex_y;
                                r_close <= 1'b0;
                                r_state <= S_M0;
                            end
                        end else begin
                            // dropped vertex, ring closes from the last kept one
                            r_ovf   <= 1'b1;
                            r_ax    <= r_prev_x;
                            r_ay    <= r_prev_y;
                            r_bx    <= r_first_x;
                            r_by    <= r_first_y;
                            r_close <= 1'b1;
                            r_state <= i_last_vertex ? S_M0 : S_IDLE;
                        end
                    end
                end
                S_M0: begin
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_c     <= PROD_W'(r_p);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_c     <= r_c - PROD_W'(r_p);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_area  <= r_area + AREA_W'(r_c);
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_wx    <= r_wx + WACC_W'(r_p);
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_wy <= r_wy + WACC_W'(r_p);
                    if (r_close) begin
                        r_state <= S_FIN0;
                    end else if (r_last) begin
                        // closing edge back to the first vertex
                        r_ax    <= r_prev_x;
                        r_ay    <= r_prev_y;
                        r_bx    <= r_first_x;
                        r_by    <= r_first_y;
                        r_close <= 1'b1;
                        r_state <= S_M0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FIN0: begin
                    r_ta    <= TA_W'(ta_sat);
                    r_nx    <= NUM_W'(nx_sat);
                    r_ny    <= NUM_W'(ny_sat);
                    r_pos   <= (area_ext > ACC_MAX_W'(I_ZERO));
                    r_state <= S_FIN1;
                end
                S_FIN1: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ta    <= r_ta;
                        r_out_nx    <= r_nx;
                        r_out_ny    <= r_ny;
                        r_out_den   <= den_calc;
                        r_out_ovf   <= r_ovf;
                        // back to an empty polygon
                        r_count     <= '0;
                        r_ovf       <= 1'b0;
                        r_first_x   <= '0;
                        r_first_y   <= '0;
                        r_prev_x    <= '0;
                        r_prev_y    <= '0;
                        r_area      <= '0;
                        r_wx        <= '0;
                        r_wy        <= '0;
                        r_px        <= '0;
                        r_py        <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_twice_area = r_out_ta;
    assign o_num_x      = r_out_nx;
    assign o_num_y      = r_out_ny;
    assign o_denom      = r_out_den;
    assign o_too_many   = r_out_ovf;

endmodule

@@ tb/tb_polygon_area_centroid_core.sv @@
`timescale 1ns / 1ps

// one finished polygon as the block should report it
typedef struct {
    logic [pac_pkg::TA_W-1:0]  area2;
    logic [pac_pkg::NUM_W-1:0] num_x;
    logic [pac_pkg::NUM_W-1:0] num_y;
    logic [pac_pkg::DEN_W-1:0] denom;
    logic                      too_many;
} t_polygon_result;

class t_centroid_scoreboard;
    t_polygon_result pending_q[$];

    // running shoelace state of the polygon being received
    longint first_x, first_y, prev_x, prev_y;
    longint area_sum, wsum_x, wsum_y, psum_x, psum_y;
    int unsigned kept;
    bit dropped;

    int errors;
    int polygons;
    int positive;
    int overflowed;

    function void add_edge(longint ax, longint ay, longint bx, longint by);
        longint c;
        c = ax * by - bx * ay;
        area_sum += c;
        wsum_x += (ax + bx) * c;
        wsum_y += (ay + by) * c;
    endfunction

    function longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function void note_vertex(logic signed [pac_pkg::DEF_COORD_BITS-1:0] vx,
                              logic signed [pac_pkg::DEF_COORD_BITS-1:0] vy,
                              logic last);
        longint x;
        longint y;
        longint ta;
        longint nx;
        longint ny;
        longint den;
        t_polygon_result r;
        x = vx;
        y = vy;
        if (kept < pac_pkg::DEF_MAX_VERTICES) begin
            if (kept == 0) begin
                first_x = x;
                first_y = y;
            end else begin
                add_edge(prev_x, prev_y, x, y);
            end
            prev_x = x;
            prev_y = y;
            psum_x += x;
            psum_y += y;
            kept++;
        end else begin
            dropped = 1'b1;
        end
        if (!last) return;

        if (kept > 0) add_edge(prev_x, prev_y, first_x, first_y);
        ta = clamp_sym(area_sum, longint'(pac_pkg::AREA_LIMIT));
        if (area_sum > 0) begin
            den = longint'(pac_pkg::I_THREE) * ta;
            nx  = clamp_sym(wsum_x, longint'(pac_pkg::NUM_LIMIT));
            ny  = clamp_sym(wsum_y, longint'(pac_pkg::NUM_LIMIT));
            positive++;
        end else begin
            den = kept;
            nx  = clamp_sym(psum_x, longint'(pac_pkg::NUM_LIMIT));
            ny  = clamp_sym(psum_y, longint'(pac_pkg::NUM_LIMIT));
        end
        if (dropped) overflowed++;
        r.area2    = ta[pac_pkg::TA_W-1:0];
        r.num_x    = nx[pac_pkg::NUM_W-1:0];
        r.num_y    = ny[pac_pkg::NUM_W-1:0];
        r.denom    = den[pac_pkg::DEN_W-1:0];
        r.too_many = dropped;
        pending_q.insert(pending_q.size(), r);

        first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
        area_sum = 0; wsum_x = 0; wsum_y = 0; psum_x = 0; psum_y = 0;
        kept = 0;
        dropped = 1'b0;
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("MISMATCH %s", msg);
    endtask

    task check_result(logic [pac_pkg::TA_W-1:0] area2, logic [pac_pkg::NUM_W-1:0] num_x,
                      logic [pac_pkg::NUM_W-1:0] num_y, logic [pac_pkg::DEN_W-1:0] denom,
                      logic too_many);
        t_polygon_result want;
        if (pending_q.size() == 0) begin
            report_mismatch("result arrived with no polygon pending");
            return;
        end
        want = pending_q.pop_front();
        polygons++;
        if (area2 !== want.area2)
            report_mismatch($sformatf("polygon %0d twice_area got %0d expected %0d",
                polygons, $signed(area2), $signed(want.area2)));
        if (num_x !== want.num_x)
            report_mismatch($sformatf("polygon %0d num_x got %0d expected %0d",
                polygons, $signed(num_x), $signed(want.num_x)));
        if (num_y !== want.num_y)
            report_mismatch($sformatf("polygon %0d num_y got %0d expected %0d",
                polygons, $signed(num_y), $signed(want.num_y)));
        if (denom !== want.denom)
            report_mismatch($sformatf("polygon %0d denom got %0d expected %0d",
                polygons, denom, want.denom));
        if (too_many !== want.too_many)
            report_mismatch($sformatf("polygon %0d too_many got %b expected %b",
                polygons, too_many, want.too_many));
    endtask
endclass

module tb_polygon_area_centroid_core;
    import pac_pkg::*;

    localparam int CW          = DEF_COORD_BITS;
    localparam int MAXV        = DEF_MAX_VERTICES;
    localparam int RANDOM_ITEMS = 170;
    // cycles without any request moving before the run is declared hung
    localparam int HANG_LIMIT  = 2000;
    // closing edge plus saturation plus the output register
    localparam int DRAIN_CYCLES = 50;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic signed [CW-1:0] i_vertex_x = '0;
    logic signed [CW-1:0] i_vertex_y = '0;
    logic                 i_last_vertex = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [TA_W-1:0]  o_twice_area;
    logic signed [NUM_W-1:0] o_num_x;
    logic signed [NUM_W-1:0] o_num_y;
    logic [DEN_W-1:0]        o_denom;
    logic                    o_too_many;

    t_centroid_scoreboard sb = new();

    // when set, neither side inserts gaps or stalls
    bit quiet = 1'b0;
    int vertices_sent = 0;

    // vertices of the polygon about to be sent, in ring order
    logic signed [CW-1:0] ring_x[$];
    logic signed [CW-1:0] ring_y[$];

    polygon_area_centroid_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_last_vertex (i_last_vertex),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_twice_area  (o_twice_area),
        .o_num_x       (o_num_x),
        .o_num_y       (o_num_y),
        .o_denom       (o_denom),
        .o_too_many    (o_too_many)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // one vertex request, with an optional random gap in front of it
    task automatic send_vertex(input logic signed [CW-1:0] vx, input logic signed [CW-1:0] vy,
                               input logic last);
        while (!quiet && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_vertex_x    <= vx;
        i_vertex_y    <= vy;
        i_last_vertex <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_vertex(vx, vy, last);
        vertices_sent++;
    endtask

    task automatic add_pt(input logic signed [CW-1:0] vx, input logic signed [CW-1:0] vy);
        ring_x.insert(ring_x.size(), vx);
        ring_y.insert(ring_y.size(), vy);
    endtask

    // send the collected ring with the last flag on its final vertex
    task automatic send_ring();
        for (int i = 0; i < ring_x.size(); i++) begin
            send_vertex(ring_x[i], ring_y[i], i == ring_x.size() - 1);
        end
        ring_x.delete();
        ring_y.delete();
    endtask

    // a square walked several times round as one polygon; repeated loops
    // pile up area and weighted sums until they saturate
    task automatic send_square(input int lo, input int hi, input int loops, input bit ccw);
        for (int l = 0; l < loops; l++) begin
            if (ccw) begin
                add_pt(CW'(lo), CW'(lo)); add_pt(CW'(hi), CW'(lo));
                add_pt(CW'(hi), CW'(hi)); add_pt(CW'(lo), CW'(hi));
            end else begin
                add_pt(CW'(lo), CW'(lo)); add_pt(CW'(lo), CW'(hi));
                add_pt(CW'(hi), CW'(hi)); add_pt(CW'(hi), CW'(lo));
            end
        end
        send_ring();
    endtask

    // result side: check accepted results, then draw the next stall
    initial begin
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall)
                sb.check_result(o_twice_area, o_num_x, o_num_y, o_denom, o_too_many);
            i_out_stall <= !quiet && ($urandom_range(99) < 23);
        end
    end

    // hang detection: any request moving on either side restarts the count
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout after %0d idle cycles", HANG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int random_sent;
        int len;
        int mode;
        int cx;
        int cy;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single vertices at the coordinate extremes and the origin come back with denom 1
        add_pt(16'sh7fff, 16'sh8000); send_ring();
        add_pt(16'sh8000, 16'sh7fff); send_ring();
        add_pt(16'sh0000, 16'sh0000); send_ring();
        // counterclockwise triangle, positive area
        add_pt(0, 0); add_pt(10, 0); add_pt(0, 10); send_ring();
        // the same triangle clockwise falls back to the vertex average
        add_pt(0, 0); add_pt(0, 10); add_pt(10, 0); send_ring();
        // collinear points, zero area
        add_pt(-5, -5); add_pt(1, 1); add_pt(7, 7); send_ring();
        // two vertices, there and back
        add_pt(16'sh8000, 16'sh8000); add_pt(16'sh7fff, 16'sh7fff); send_ring();
        // largest square, once round
        send_square(-32768, 32767, 1, 1'b1);

        // hold the sender until every polygon so far has been reported
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);

        // saturation: area and positive numerators, negative numerators,
        // and a clockwise ring whose area saturates below zero
        send_square(0, 32767, 12, 1'b1);
        send_square(-32768, 0, 12, 1'b1);
        send_square(-32768, 32767, 3, 1'b0);

        // vertex limit: the ring fills up exactly, one vertex is dropped
        // before the last and the last flag rides on a second dropped one
        for (int i = 0; i < MAXV + 2; i++)
            add_pt(CW'($urandom_range(8191) - 4096), CW'($urandom_range(8191) - 4096));
        send_ring();

        // random polygons, mostly short, some long, with a stretch of
        // back-to-back traffic in the middle
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            quiet = (random_sent >= 40 && random_sent < 110);
            len  = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
            mode = $urandom_range(3);
            cx   = $urandom_range(65535) - 32768;
            cy   = $urandom_range(65535) - 32768;
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0: add_pt(CW'($urandom_range(65535)), CW'($urandom_range(65535)));
                    // tight cluster somewhere in the plane
                    1: add_pt(CW'(cx + $urandom_range(32) - 16), CW'(cy + $urandom_range(32) - 16));
                    // only corner and near-zero values
                    2: add_pt($urandom_range(1) ? ($urandom_range(1) ? 16'sh7fff : 16'sh8000)
                                                : CW'($urandom_range(1) - 1),
                              $urandom_range(1) ? ($urandom_range(1) ? 16'sh7fff : 16'sh8000)
                                                : CW'($urandom_range(1) - 1));
                    default: add_pt(CW'($urandom_range(2047) - 1024),
                                    CW'($urandom_range(2047) - 1024));
                endcase
            end
            send_ring();
            random_sent += len;
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d vertices sent, %0d polygons checked (%0d with positive area)",
                 vertices_sent, sb.polygons, sb.positive);
        $display("%0d polygons ran past the vertex limit, %0d mismatches",
                 sb.overflowed, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/pac_pkg.sv
hdl/polygon_area_centroid_core.sv
tb/tb_polygon_area_centroid_core.sv
